/* src/plpm_pkg.sv */
`timescale 1ns / 1ps

package plpm_pkg;

    localparam int SAMPLE_W = 10;
    localparam int FREQ_W   = 10;
    localparam int HALF_W   = 13;
    localparam int NUM_W    = 20;
    localparam int KNEES    = 8;
    localparam int SEG_W    = 3;

    // interpolation divider: (sample - knee) * 100 / segment width
    localparam int IP_REM_W = 15;
    localparam int IP_DEN_W = 9;
    localparam int IP_Q_W   = 7;

    // half period divider: numerator / frequency
    localparam int HP_REM_W = NUM_W;
    localparam int HP_DEN_W = FREQ_W;
    localparam int HP_Q_W   = HALF_W;

    localparam logic [HALF_W-1:0] HALF_PERIOD_MAX = 13'd5000;
    localparam logic [NUM_W-1:0]  NUMERATOR_RESET = 20'd500000;
    localparam logic [6:0]        STEP_HZ         = 7'd100;

    typedef logic [SAMPLE_W-1:0] t_sample;
    typedef logic [FREQ_W-1:0]   t_freq;

    localparam t_sample KNEE_IN [KNEES] =
        '{10'd0, 10'd15, 10'd40, 10'd100, 10'd250, 10'd500, 10'd800, 10'd1023};
    localparam t_freq KNEE_HZ [KNEES] =
        '{10'd200, 10'd300, 10'd400, 10'd500, 10'd600, 10'd700, 10'd800, 10'd900};

endpackage

/* src/plpm_seg.sv */
`timescale 1ns / 1ps

module plpm_seg (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic [plpm_pkg::SAMPLE_W-1:0]        i_sample,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic [plpm_pkg::IP_REM_W-1:0]        o_num,
    output logic [plpm_pkg::IP_DEN_W-1:0]        o_dx,
    output logic [plpm_pkg::FREQ_W-1:0]          o_base
);

    logic                              r_valid;
    logic [plpm_pkg::IP_REM_W-1:0]     r_num;
    logic [plpm_pkg::IP_DEN_W-1:0]     r_dx;
    logic [plpm_pkg::FREQ_W-1:0]       r_base;

    logic [plpm_pkg::SEG_W-1:0]        n_seg;
    logic [plpm_pkg::SAMPLE_W-1:0]     n_lo;
    logic [plpm_pkg::SAMPLE_W-1:0]     n_hi;
    logic [plpm_pkg::SAMPLE_W-1:0]     n_off;
    logic [plpm_pkg::IP_REM_W-1:0]     n_num;

    // lowest segment holding the sample: count interior knees strictly below it.
    // Clamping falls out: sample 0 gives offset 0, sample 1023 gives full step.
    always_comb begin
        n_seg = '0;
        for (int j = 1; j < plpm_pkg::KNEES - 1; j++) begin
            if (i_sample > plpm_pkg::KNEE_IN[j]) begin
                n_seg = n_seg + 1'b1;
            end
        end
        n_lo  = plpm_pkg::KNEE_IN[n_seg];
        n_hi  = plpm_pkg::KNEE_IN[n_seg + 1'b1];
        n_off = i_sample - n_lo;
        n_num = plpm_pkg::IP_REM_W'(n_off * plpm_pkg::STEP_HZ);
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (i_valid && o_ready) begin
            r_num  <= n_num;
            r_dx   <= plpm_pkg::IP_DEN_W'(n_hi - n_lo);
            r_base <= plpm_pkg::KNEE_HZ[n_seg];
        end
    end

    assign o_valid = r_valid;
    assign o_num   = r_num;
    assign o_dx    = r_dx;
    assign o_base  = r_base;

endmodule

/* src/plpm_div_cell.sv */
`timescale 1ns / 1ps

module plpm_div_cell #(
    parameter int REM_W  = 20,
    parameter int DEN_W  = 10,
    parameter int Q_W    = 13,
    parameter int BIT    = 12,
    parameter int SIDE_W = 10
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_up_valid,
    output logic              o_up_ready,
    output logic              o_dn_valid,
    input  logic              i_dn_ready,
    input  logic [REM_W-1:0]  i_rem,
    input  logic [DEN_W-1:0]  i_den,
    input  logic [Q_W-1:0]    i_quo,
    input  logic [SIDE_W-1:0] i_side,
    output logic [REM_W-1:0]  o_rem,
    output logic [DEN_W-1:0]  o_den,
    output logic [Q_W-1:0]    o_quo,
    output logic [SIDE_W-1:0] o_side
);

    localparam int CMP_W = (REM_W > DEN_W + Q_W) ? REM_W : DEN_W + Q_W;

    logic              r_valid;
    logic [REM_W-1:0]  r_rem;
    logic [DEN_W-1:0]  r_den;
    logic [Q_W-1:0]    r_quo;
    logic [SIDE_W-1:0] r_side;

    logic [CMP_W-1:0]  n_rem_x;
    logic [CMP_W-1:0]  n_den_sh;
    logic              n_take;
    logic [REM_W-1:0]  n_rem;
    logic [Q_W-1:0]    n_quo;

    // one restoring step: try subtracting the divisor at this quotient weight
    always_comb begin
        n_rem_x  = CMP_W'(i_rem);
        n_den_sh = CMP_W'(i_den) << BIT;
        n_take   = n_rem_x >= n_den_sh;
        n_rem    = n_take ? REM_W'(n_rem_x - n_den_sh) : i_rem;
        n_quo    = i_quo | (Q_W'(n_take) << BIT);
    end

    assign o_up_ready = !r_valid || i_dn_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_up_ready) begin
            r_valid <= i_up_valid;
        end
        if (i_up_valid && o_up_ready) begin
            r_rem  <= n_rem;
            r_den  <= i_den;
            r_quo  <= n_quo;
            r_side <= i_side;
        end
    end

    assign o_dn_valid = r_valid;
    assign o_rem      = r_rem;
    assign o_den      = r_den;
    assign o_quo      = r_quo;
    assign o_side     = r_side;

endmodule

/* src/piecewise_linear_pitch_map.sv */
`timescale 1ns / 1ps

// Knob sample to tone pitch. Input channel: i_valid / o_stall with i_sample;
// a request is taken on a rising edge with i_valid high and o_stall low.
// Output channel: o_valid / i_stall with o_frequency_hz and o_half_period_us.
// Configuration: i_cfg_valid / o_cfg_ready with i_cfg_data, the 20-bit
// half period numerator; o_cfg_ready is always high. Write it only while idle.
// The chain has one segment-select step, 7 interpolation divider
// cells (one quotient bit each) and 13 half-period divider cells, one cell
// per quotient bit of the numerator / frequency division.
// It takes one request per cycle while o_stall is low; every cell holds
// its own request and hands it on as soon as the next cell can take it,
// so bubbles close up. While the receiver stalls the last cell holds its
// result steady, and the chain keeps accepting until every cell is full;
// then o_stall rises. Reset (synchronous, active low) empties the chain
// and restores the numerator to 500000.
module piecewise_linear_pitch_map (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [plpm_pkg::SAMPLE_W-1:0]   i_sample,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [plpm_pkg::FREQ_W-1:0]     o_frequency_hz,
    output logic [plpm_pkg::HALF_W-1:0]     o_half_period_us,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [plpm_pkg::NUM_W-1:0]      i_cfg_data
);

    localparam int IP_N = plpm_pkg::IP_Q_W;
    localparam int HP_N = plpm_pkg::HP_Q_W;

    logic [plpm_pkg::NUM_W-1:0]     r_numerator;

    logic                           seg_ready;

    logic                           a_valid [IP_N+1];
    logic                           a_ready [IP_N+1];
    logic [plpm_pkg::IP_REM_W-1:0]  a_rem   [IP_N+1];
    logic [plpm_pkg::IP_DEN_W-1:0]  a_den   [IP_N+1];
    logic [plpm_pkg::IP_Q_W-1:0]    a_quo   [IP_N+1];
    logic [plpm_pkg::FREQ_W-1:0]    a_side  [IP_N+1];

    logic                           b_valid [HP_N+1];
    logic                           b_ready [HP_N+1];
    logic [plpm_pkg::HP_REM_W-1:0]  b_rem   [HP_N+1];
    logic [plpm_pkg::HP_DEN_W-1:0]  b_den   [HP_N+1];
    logic [plpm_pkg::HP_Q_W-1:0]    b_quo   [HP_N+1];
    logic [plpm_pkg::FREQ_W-1:0]    b_side  [HP_N+1];

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_numerator <= plpm_pkg::NUMERATOR_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_numerator <= i_cfg_data;
        end
    end

    plpm_seg u_seg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (seg_ready),
        .i_sample (i_sample),
        .o_valid  (a_valid[0]),
        .i_ready  (a_ready[0]),
        .o_num    (a_rem[0]),
        .o_dx     (a_den[0]),
        .o_base   (a_side[0])
    );

    assign o_stall  = !seg_ready;
    assign a_quo[0] = '0;

    for (genvar j = 0; j < IP_N; j++) begin : g_ip
        plpm_div_cell #(
            .REM_W  (plpm_pkg::IP_REM_W),
            .DEN_W  (plpm_pkg::IP_DEN_W),
            .Q_W    (plpm_pkg::IP_Q_W),
            .BIT    (IP_N - 1 - j),
            .SIDE_W (plpm_pkg::FREQ_W)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_up_valid (a_valid[j]),
            .o_up_ready (a_ready[j]),
            .o_dn_valid (a_valid[j+1]),
            .i_dn_ready (a_ready[j+1]),
            .i_rem      (a_rem[j]),
            .i_den      (a_den[j]),
            .i_quo      (a_quo[j]),
            .i_side     (a_side[j]),
            .o_rem      (a_rem[j+1]),
            .o_den      (a_den[j+1]),
            .o_quo      (a_quo[j+1]),
            .o_side     (a_side[j+1])
        );
    end

    // frequency = segment base + interpolated step; it seeds the second divider
    assign b_valid[0]   = a_valid[IP_N];
    assign a_ready[IP_N] = b_ready[0];
    assign b_rem[0]     = r_numerator;
    assign b_den[0]     = a_side[IP_N] + plpm_pkg::FREQ_W'(a_quo[IP_N]);
    assign b_side[0]    = b_den[0];
    assign b_quo[0]     = '0;

    for (genvar j = 0; j < HP_N; j++) begin : g_hp
        plpm_div_cell #(
            .REM_W  (plpm_pkg::HP_REM_W),
            .DEN_W  (plpm_pkg::HP_DEN_W),
            .Q_W    (plpm_pkg::HP_Q_W),
            .BIT    (HP_N - 1 - j),
            .SIDE_W (plpm_pkg::FREQ_W)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_up_valid (b_valid[j]),
            .o_up_ready (b_ready[j]),
            .o_dn_valid (b_valid[j+1]),
            .i_dn_ready (b_ready[j+1]),
            .i_rem      (b_rem[j]),
            .i_den      (b_den[j]),
            .i_quo      (b_quo[j]),
            .i_side     (b_side[j]),
            .o_rem      (b_rem[j+1]),
            .o_den      (b_den[j+1]),
            .o_quo      (b_quo[j+1]),
            .o_side     (b_side[j+1])
        );
    end

    assign b_ready[HP_N]  = !i_stall;
    assign o_valid        = b_valid[HP_N];
    assign o_frequency_hz = b_side[HP_N];
    assign o_half_period_us = (b_quo[HP_N] > plpm_pkg::HALF_PERIOD_MAX)
                            ? plpm_pkg::HALF_PERIOD_MAX : b_quo[HP_N];

endmodule

/* tb/pitch_map_checker.sv */
`timescale 1ns / 1ps

module pitch_map_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_req_valid,
    input  logic                          i_req_stall,
    input  logic [plpm_pkg::SAMPLE_W-1:0] i_sample,
    input  logic                          i_rsp_valid,
    input  logic                          i_rsp_stall,
    input  logic [plpm_pkg::FREQ_W-1:0]   i_frequency_hz,
    input  logic [plpm_pkg::HALF_W-1:0]   i_half_period_us,
    input  logic                          i_cfg_valid,
    input  logic                          i_cfg_ready,
    input  logic [plpm_pkg::NUM_W-1:0]    i_cfg_data,
    output int                            o_fail_count,
    output int                            o_pending,
    output int                            o_checked
);

    typedef struct packed {
        plpm_pkg::t_freq             freq;
        logic [plpm_pkg::HALF_W-1:0] half;
    } t_pitch;

    t_pitch                     pending_pitches[$];
    logic [plpm_pkg::NUM_W-1:0] numerator;

    function automatic plpm_pkg::t_freq interp_freq(input plpm_pkg::t_sample s);
        int x;
        int x0;
        int x1;
        int y0;
        int y1;
        x = int'(s);
        if (x <= int'(plpm_pkg::KNEE_IN[0])) return plpm_pkg::KNEE_HZ[0];
        if (x >= int'(plpm_pkg::KNEE_IN[plpm_pkg::KNEES-1])) begin
            return plpm_pkg::KNEE_HZ[plpm_pkg::KNEES-1];
        end
        // lowest segment wins on a breakpoint
        for (int k = 0; k < plpm_pkg::KNEES - 1; k++) begin
            x0 = int'(plpm_pkg::KNEE_IN[k]);
            x1 = int'(plpm_pkg::KNEE_IN[k+1]);
            y0 = int'(plpm_pkg::KNEE_HZ[k]);
            y1 = int'(plpm_pkg::KNEE_HZ[k+1]);
            if (x >= x0 && x <= x1) begin
                return plpm_pkg::t_freq'(y0 + ((x - x0) * (y1 - y0)) / (x1 - x0));
            end
        end
        return plpm_pkg::KNEE_HZ[0];
    endfunction

    function automatic t_pitch predict_pitch(input plpm_pkg::t_sample s,
                                             input logic [plpm_pkg::NUM_W-1:0] num);
        t_pitch                     p;
        logic [plpm_pkg::NUM_W-1:0] q;
        p.freq = interp_freq(s);
        q      = num / p.freq;
        p.half = (q > plpm_pkg::HALF_PERIOD_MAX) ? plpm_pkg::HALF_PERIOD_MAX
                                                 : q[plpm_pkg::HALF_W-1:0];
        return p;
    endfunction

    always @(posedge i_clk) begin
        t_pitch want;
        int     fails;
        int     depth;
        int     seen;
        fails = o_fail_count;
        depth = o_pending;
        seen  = o_checked;
        if (!i_rst_n) begin
            pending_pitches.delete();
            numerator = plpm_pkg::NUMERATOR_RESET;
            depth     = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) numerator = i_cfg_data;
            // results leave before new requests enter; latency keeps them distinct
            if (i_rsp_valid && !i_rsp_stall) begin
                seen++;
                if (pending_pitches.size() == 0) begin
                    $error("result with no request outstanding: %s %0d, %s %0d",
                           "frequency_hz", i_frequency_hz,
                           "half_period_us", i_half_period_us);
                    fails++;
                end else begin
                    want = pending_pitches.pop_front();
                    depth--;
                    if (i_frequency_hz !== want.freq) begin
                        $error("frequency_hz mismatch: expected %0d, actual %0d",
                               want.freq, i_frequency_hz);
                        fails++;
                    end
                    if (i_half_period_us !== want.half) begin
                        $error("half_period_us mismatch: expected %0d, actual %0d",
                               want.half, i_half_period_us);
                        fails++;
                    end
                end
            end
            if (i_req_valid && !i_req_stall) begin
                pending_pitches.push_back(predict_pitch(i_sample, numerator));
                depth++;
            end
        end
        o_fail_count <= fails;
        o_pending    <= depth;
        o_checked    <= seen;
    end

endmodule

/* tb/piecewise_linear_pitch_map_tb.sv */
`timescale 1ns / 1ps

module piecewise_linear_pitch_map_tb;

    localparam int PHASES           = 8;
    localparam int RANDOM_PER_PHASE = 128;
    localparam int HOLD_CYCLES      = 120;
    localparam int DRAIN_CYCLES     = 30;

    localparam plpm_pkg::t_sample CORNER_SAMPLES [24] = '{
        10'd0, 10'd1, 10'd14, 10'd15, 10'd16, 10'd39, 10'd40, 10'd41,
        10'd99, 10'd100, 10'd101, 10'd249, 10'd250, 10'd251, 10'd499, 10'd500,
        10'd501, 10'd799, 10'd800, 10'd801, 10'd1022, 10'd1023, 10'd341, 10'd682
    };

    logic                        i_clk            = 1'b0;
    logic                        i_rst_n          = 1'b0;
    logic                        i_valid          = 1'b0;
    logic                        o_stall;
    plpm_pkg::t_sample           i_sample         = '0;
    logic                        o_valid;
    logic                        i_stall          = 1'b0;
    plpm_pkg::t_freq             o_frequency_hz;
    logic [plpm_pkg::HALF_W-1:0] o_half_period_us;
    logic                        i_cfg_valid      = 1'b0;
    logic                        o_cfg_ready;
    logic [plpm_pkg::NUM_W-1:0]  i_cfg_data       = '0;

    int fail_count;
    int pending;
    int checked;
    int samples_sent   = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_req       = 0;
    int hold_ack       = 0;
    int hold_left      = 0;

    piecewise_linear_pitch_map u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_sample         (i_sample),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_frequency_hz   (o_frequency_hz),
        .o_half_period_us (o_half_period_us),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_data       (i_cfg_data)
    );

    pitch_map_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_req_valid      (i_valid),
        .i_req_stall      (o_stall),
        .i_sample         (i_sample),
        .i_rsp_valid      (o_valid),
        .i_rsp_stall      (i_stall),
        .i_frequency_hz   (o_frequency_hz),
        .i_half_period_us (o_half_period_us),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_ready      (o_cfg_ready),
        .i_cfg_data       (i_cfg_data),
        .o_fail_count     (fail_count),
        .o_pending        (pending),
        .o_checked        (checked)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // receiver: random stalls, plus a long hold-off on request
    always @(posedge i_clk) begin
        if (hold_req != hold_ack) begin
            hold_ack  <= hold_req;
            hold_left <= HOLD_CYCLES;
            i_stall   <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_stall   <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    function automatic plpm_pkg::t_sample pick_sample();
        int k;
        int r;
        // a quarter of the samples sit on or next to a breakpoint
        if ($urandom_range(3) == 0) begin
            k = $urandom_range(plpm_pkg::KNEES - 1);
            r = int'(plpm_pkg::KNEE_IN[k]) + int'($urandom_range(2)) - 1;
            if (r < 0) r = 0;
            if (r > 1023) r = 1023;
            return plpm_pkg::t_sample'(r);
        end
        return plpm_pkg::t_sample'($urandom_range(1023));
    endfunction

    task automatic offer_sample(input plpm_pkg::t_sample s);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_sample <= s;
        do @(posedge i_clk); while (o_stall);
        samples_sent++;
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_numerator(input logic [plpm_pkg::NUM_W-1:0] num);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= num;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        logic [plpm_pkg::NUM_W-1:0] num;
        int                         idle;
        int                         stall;
        bit                         hold;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (CORNER_SAMPLES[i]) offer_sample(CORNER_SAMPLES[i]);

        for (int ph = 0; ph < PHASES; ph++) begin
            hold = 1'b0;
            num  = plpm_pkg::NUMERATOR_RESET;
            unique case (ph)
                0: begin idle = 0;  stall = 0;  end
                1: begin idle = 58; stall = 0;  num = 20'd1000000; end
                2: begin idle = 0;  stall = 58; num = 20'd1; end
                3: begin idle = 6;  stall = 6;  num = 20'hFFFFF; end
                4: begin idle = 0;  stall = 0;  num = '0; hold = 1'b1; end
                5: begin
                    idle  = 58;
                    stall = 0;
                    num   = plpm_pkg::NUM_W'($urandom_range(1, 1000000));
                end
                6: begin idle = 0;  stall = 58; num = plpm_pkg::NUM_W'($urandom); end
                default: begin idle = 6; stall = 6; end
            endcase
            if (ph != 0) write_numerator(num);
            send_idle_pct  = idle;
            recv_stall_pct <= stall;
            // sender keeps going through the hold-off so the chain backs up
            if (hold) hold_req <= hold_req + 1;
            repeat (RANDOM_PER_PHASE) offer_sample(pick_sample());
        end
        drain();

        $display("Sent %0d knob samples, checked %0d pitch results, over %0d phases",
                 samples_sent, checked, PHASES);
        $display("Covered breakpoints, numerator 0/1/max/reset/random, stalls, hold-off");
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
